FILE: design/assert_macros.svh
// Assertion macros shared by the adaptive filter modules.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lms assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lms assertion failed");

`endif

FILE: design/lms_pkg.sv
// Shared constants, controller states and the control bundle of the LMS filter.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package lms_pkg;

    localparam int TAPS     = 256;
    localparam int IDX_W    = $clog2(TAPS);
    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 32;
    localparam int FRAC     = 24;
    localparam int SHIFT_W  = 6;
    localparam int PROD_W   = WEIGHT_W + SAMPLE_W;
    localparam int ACC_W    = PROD_W + $clog2(TAPS);
    localparam int Y_W      = ACC_W - FRAC;

    localparam logic [SHIFT_W-1:0] STEP_SHIFT_RESET = SHIFT_W'(19);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_MDRAIN,
        ST_FIN,
        ST_UPD,
        ST_UDRAIN
    } t_state;

    typedef struct packed {
        logic             clr;
        logic             start;
        logic             fin;
        logic             iss_vld;
        logic             iss_upd;
        logic [IDX_W-1:0] idx;
        logic             s_we;
        logic [IDX_W-1:0] s_waddr;
        logic [IDX_W-1:0] s_raddr;
    } t_lms_ctl;

endpackage

`default_nettype wire

FILE: design/lms_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; used for the weight store and the sample delay line.
`default_nettype none

module lms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: design/lms_ctrl.sv
// Sequencer of the LMS filter: clearing sweep, filter pass, update pass, delay-line pointer.
// Depends on lms_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lms_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic              i_out_free,
    output lms_pkg::t_lms_ctl      o_ctl
);

    import lms_pkg::*;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(TAPS - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_base, n_base;
    logic             r_drain, n_drain;
    logic [IDX_W-1:0] w_raddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
            r_head  <= '0;
            r_base  <= '0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_head  <= n_head;
            r_base  <= n_base;
            r_drain <= n_drain;
        end
    end

    // Tap i of the delay line sits i places behind the newest sample, modulo the depth.
    always_comb begin
        if (r_base >= r_idx) begin
            w_raddr = r_base - r_idx;
        end else begin
            w_raddr = IDX_W'({1'b0, r_base} + (IDX_W + 1)'(TAPS) - {1'b0, r_idx});
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_head  = r_head;
        n_base  = r_base;
        n_drain = r_drain;

        o_ctl         = '0;
        o_ctl.idx     = r_idx;
        o_ctl.s_waddr = r_head;
        o_ctl.s_raddr = w_raddr;

        unique case (r_state)
            ST_CLEAR: begin
                o_ctl.clr     = 1'b1;
                o_ctl.s_we    = 1'b1;
                o_ctl.s_waddr = r_idx;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_ctl.start = 1'b1;
                    o_ctl.s_we  = 1'b1;
                    n_base      = r_head;
                    n_head      = (r_head == LAST) ? '0 : r_head + 1'b1;
                    n_idx       = '0;
                    n_state     = ST_MAC;
                end
            end
            ST_MAC: begin
                o_ctl.iss_vld = 1'b1;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_drain = 1'b0;
                    n_state = ST_MDRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_MDRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_out_free) begin
                    o_ctl.fin = 1'b1;
                    n_idx     = '0;
                    n_state   = ST_UPD;
                end
            end
            ST_UPD: begin
                o_ctl.iss_vld = 1'b1;
                o_ctl.iss_upd = 1'b1;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_drain = 1'b0;
                    n_state = ST_UDRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_UDRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_idx   = '0;
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_s_tready = (r_state == ST_IDLE);

    `LMS_ASSERT_NEXT(a_accept_starts_mac, i_clk, i_rst_n, i_s_tvalid && o_s_tready, (r_state == ST_MAC) && (r_idx == '0))
    `LMS_ASSERT_IMPL(a_fin_needs_slot, i_clk, i_rst_n, o_ctl.fin, i_out_free)
    `LMS_ASSERT_NEXT(a_mac_ends, i_clk, i_rst_n, (r_state == ST_MAC) && (r_idx == LAST), r_state == ST_MDRAIN)

endmodule

`default_nettype wire

FILE: design/lms_dp.sv
// Datapath of the LMS filter: shared multiplier, accumulator, error and weight update.
// Depends on lms_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lms_dp (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire lms_pkg::t_lms_ctl                         i_ctl,
    input  wire logic signed [lms_pkg::SAMPLE_W-1:0]       i_desired,
    input  wire logic        [lms_pkg::SHIFT_W-1:0]        i_step_shift,
    input  wire logic signed [lms_pkg::WEIGHT_W-1:0]       i_w_rdata,
    input  wire logic signed [lms_pkg::SAMPLE_W-1:0]       i_s_rdata,
    output logic                                           o_w_we,
    output logic             [lms_pkg::IDX_W-1:0]          o_w_waddr,
    output logic             [lms_pkg::WEIGHT_W-1:0]       o_w_wdata,
    output logic                                           o_out_free,
    output logic                                           o_m_tvalid,
    input  wire logic                                      i_m_tready,
    output logic signed [lms_pkg::SAMPLE_W-1:0]            o_filter_out,
    output logic signed [lms_pkg::SAMPLE_W-1:0]            o_error_out
);

    import lms_pkg::*;

    localparam logic signed [Y_W:0] SAT_HI = (Y_W + 1)'(32767);
    localparam logic signed [Y_W:0] SAT_LO = (Y_W + 1)'(-32768);

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [Y_W:0] v);
        logic signed [SAMPLE_W-1:0] res;
        if (v > SAT_HI) begin
            res = SAMPLE_W'(SAT_HI);
        end else if (v < SAT_LO) begin
            res = SAMPLE_W'(SAT_LO);
        end else begin
            res = SAMPLE_W'(v);
        end
        return res;
    endfunction

    logic signed [SAMPLE_W-1:0] r_desired;
    logic                       r_d_vld, r_d_upd;
    logic [IDX_W-1:0]           r_d_idx;
    logic                       r_p_vld, r_p_upd;
    logic [IDX_W-1:0]           r_p_idx;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [WEIGHT_W-1:0] r_w;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_err;
    logic                       r_out_vld;
    logic signed [SAMPLE_W-1:0] r_y, r_e;

    logic signed [WEIGHT_W-1:0] w_mul_a;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [WEIGHT_W-1:0] w_delta;
    logic signed [WEIGHT_W:0]   w_sum;
    logic signed [WEIGHT_W-1:0] w_new;
    logic signed [Y_W-1:0]      w_y;
    logic signed [Y_W:0]        w_err_wide;

    // The filter pass multiplies weight by sample; the update pass multiplies error by sample.
    assign w_mul_a = r_d_upd ? WEIGHT_W'(r_err) : i_w_rdata;
    assign w_prod  = w_mul_a * i_s_rdata;

    assign w_delta = $signed(r_prod[WEIGHT_W-1:0]) >>> i_step_shift;
    assign w_sum   = {r_w[WEIGHT_W-1], r_w} + {w_delta[WEIGHT_W-1], w_delta};

    always_comb begin
        if (w_sum[WEIGHT_W] != w_sum[WEIGHT_W-1]) begin
            w_new = w_sum[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                    : {1'b0, {(WEIGHT_W-1){1'b1}}};
        end else begin
            w_new = w_sum[WEIGHT_W-1:0];
        end
    end

    assign w_y        = r_acc[ACC_W-1:FRAC];
    assign w_err_wide = (Y_W + 1)'(r_desired) - (Y_W + 1)'(w_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld   <= 1'b0;
            r_d_upd   <= 1'b0;
            r_p_vld   <= 1'b0;
            r_p_upd   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_d_vld <= i_ctl.iss_vld;
            r_d_upd <= i_ctl.iss_upd;
            r_p_vld <= r_d_vld;
            r_p_upd <= r_d_upd;
            if (i_ctl.fin) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_idx <= i_ctl.idx;
        r_p_idx <= r_d_idx;
        r_prod  <= w_prod;
        r_w     <= i_w_rdata;
        if (i_ctl.start) begin
            r_desired <= i_desired;
            r_acc     <= '0;
        end else if (r_p_vld && !r_p_upd) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_ctl.fin) begin
            r_err <= sat16(w_err_wide);
            r_e   <= sat16(w_err_wide);
            r_y   <= sat16((Y_W + 1)'(w_y));
        end
    end

    assign o_w_we       = i_ctl.clr || (r_p_vld && r_p_upd);
    assign o_w_waddr    = i_ctl.clr ? i_ctl.idx : r_p_idx;
    assign o_w_wdata    = i_ctl.clr ? '0 : w_new;
    assign o_out_free   = !r_out_vld || i_m_tready;
    assign o_m_tvalid   = r_out_vld;
    assign o_filter_out = r_y;
    assign o_error_out  = r_e;

    `LMS_ASSERT_NEXT(a_fin_loads_out, i_clk, i_rst_n, i_ctl.fin, r_out_vld)
    `LMS_ASSERT_IMPL(a_clear_pipe_empty, i_clk, i_rst_n, i_ctl.clr, !r_d_vld && !r_p_vld)

endmodule

`default_nettype wire

FILE: design/lms_adaptive_fir_core.sv
// Usage of the LMS adaptive FIR core.
// Input words on s_axis carry a reference sample and a desired sample; each accepted
// word yields exactly one output word on m_axis with the filter output and the error.
// The step_shift register is written on the cfg channel, which is always ready.
// Tap weights and delay-line samples sit in two single-port-read RAMs of 256 entries.
// After reset a clearing sweep writes zero to all 256 entries of both RAMs, with
// s_axis_tready low; step_shift returns to 19 at once.
// Per word: an accept step, a multiply-accumulate pass over the 256 taps (one RAM read
// per cycle), a pipeline drain, a step to form the result, an update pass that reads,
// updates and writes back one weight per tap, and a second pipeline drain.
// The output word is valid before the weight update.
// The result sits in an output register; if m_axis stalls, the core still accepts
// and filters the next word and then waits before its update pass until the slot frees.
// Depends on lms_pkg, lms_ctrl, lms_dp and lms_ram.
`default_nettype none

module lms_adaptive_fir_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] reference_sample, [31:16] desired_sample
    input  wire logic [31:0]                  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [15:0] filter_out, [31:16] error_out
    output logic      [31:0]                  m_axis_tdata,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [lms_pkg::SHIFT_W-1:0]  i_cfg_data
);

    import lms_pkg::*;

    t_lms_ctl                   w_ctl;
    logic                       w_out_free;
    logic [SHIFT_W-1:0]         r_step_shift;
    logic                       w_w_we;
    logic [IDX_W-1:0]           w_w_waddr;
    logic [WEIGHT_W-1:0]        w_w_wdata;
    logic [WEIGHT_W-1:0]        w_w_rdata;
    logic [SAMPLE_W-1:0]        w_s_wdata;
    logic [SAMPLE_W-1:0]        w_s_rdata;
    logic signed [SAMPLE_W-1:0] w_filter_out;
    logic signed [SAMPLE_W-1:0] w_error_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_shift <= STEP_SHIFT_RESET;
        end else if (i_cfg_valid) begin
            r_step_shift <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_s_wdata   = w_ctl.clr ? '0 : s_axis_tdata[SAMPLE_W-1:0];

    lms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl)
    );

    lms_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (TAPS)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_w_we),
        .i_waddr (w_w_waddr),
        .i_wdata (w_w_wdata),
        .i_raddr (w_ctl.idx),
        .o_rdata (w_w_rdata)
    );

    lms_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAPS)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (w_ctl.s_we),
        .i_waddr (w_ctl.s_waddr),
        .i_wdata (w_s_wdata),
        .i_raddr (w_ctl.s_raddr),
        .o_rdata (w_s_rdata)
    );

    lms_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_desired    (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .i_step_shift (r_step_shift),
        .i_w_rdata    (w_w_rdata),
        .i_s_rdata    (w_s_rdata),
        .o_w_we       (w_w_we),
        .o_w_waddr    (w_w_waddr),
        .o_w_wdata    (w_w_wdata),
        .o_out_free   (w_out_free),
        .o_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_filter_out (w_filter_out),
        .o_error_out  (w_error_out)
    );

    assign m_axis_tdata = {w_error_out, w_filter_out};

endmodule

`default_nettype wire

FILE: bench/lms_fir_checker.sv
// Checker for the LMS adaptive FIR core. It watches the input, output and step_shift
// channels, predicts every output word with its own fixed-point filter and compares.
// Depends on lms_pkg for the tap count, the fraction width and the reset step shift.
module lms_fir_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    input  wire logic                         i_s_tready,
    input  wire logic [31:0]                  i_s_tdata,
    input  wire logic                         i_m_tvalid,
    input  wire logic                         i_m_tready,
    input  wire logic [31:0]                  i_m_tdata,
    input  wire logic                         i_cfg_valid,
    input  wire logic                         i_cfg_ready,
    input  wire logic [lms_pkg::SHIFT_W-1:0]  i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);

    localparam int     TAPS  = lms_pkg::TAPS;
    localparam longint W_MAX = 64'sd2147483647;
    localparam longint W_MIN = -64'sd2147483648;
    localparam longint S_MAX = 64'sd32767;
    localparam longint S_MIN = -64'sd32768;

    typedef struct packed {
        logic [15:0] error_out;
        logic [15:0] filter_out;
    } t_filter_word;

    int                          coef [TAPS];
    shortint                     hist [TAPS];
    logic [lms_pkg::SHIFT_W-1:0] step_shift = lms_pkg::STEP_SHIFT_RESET;
    t_filter_word                filter_words_q [$];
    int                          fails = 0;

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic t_filter_word filter_and_adapt(input shortint ref_s, input shortint des_s);
        longint       acc;
        longint       y;
        longint       err;
        longint       delta;
        t_filter_word word;
        acc = 0;
        hist[0] = ref_s;
        for (int k = 0; k < TAPS; k++) begin
            acc += longint'(coef[k]) * longint'(hist[k]);
        end
        y   = acc >>> lms_pkg::FRAC;
        err = clamp(longint'(des_s) - y, S_MIN, S_MAX);
        for (int k = 0; k < TAPS; k++) begin
            delta   = (err * longint'(hist[k])) >>> step_shift;
            coef[k] = int'(clamp(longint'(coef[k]) + delta, W_MIN, W_MAX));
        end
        for (int k = TAPS - 1; k > 0; k--) begin
            hist[k] = hist[k-1];
        end
        word.filter_out = 16'(clamp(y, S_MIN, S_MAX));
        word.error_out  = 16'(err);
        return word;
    endfunction

    always @(posedge i_clk) begin : watch
        t_filter_word got;
        t_filter_word want;
        if (!i_rst_n) begin
            foreach (coef[k]) begin
                coef[k] = 0;
                hist[k] = 0;
            end
            step_shift = lms_pkg::STEP_SHIFT_RESET;
            filter_words_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (filter_words_q.size() == 0) begin
                    fails++;
                    $error("output word %h arrived with no filter result pending", got);
                end else begin
                    want = filter_words_q.pop_front();
                    if (got.filter_out !== want.filter_out) begin
                        fails++;
                        $error("filter_out: expected %0d, actual %0d",
                               $signed(want.filter_out), $signed(got.filter_out));
                    end
                    if (got.error_out !== want.error_out) begin
                        fails++;
                        $error("error_out: expected %0d, actual %0d",
                               $signed(want.error_out), $signed(got.error_out));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                filter_words_q.push_back(filter_and_adapt(shortint'(i_s_tdata[15:0]),
                                                          shortint'(i_s_tdata[31:16])));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                step_shift = i_cfg_data;
            end
        end
        o_fail_count <= fails;
        o_pending    <= filter_words_q.size();
    end

endmodule

FILE: bench/lms_adaptive_fir_core_tb.sv
// Testbench top for the LMS adaptive FIR core: clock, reset, input and output traffic,
// step_shift writes between phases, a watchdog and the final verdict.
// Depends on lms_pkg, the core lms_adaptive_fir_core and the checker lms_fir_checker.
module lms_adaptive_fir_core_tb;

    localparam int N_PHASES          = 10;
    localparam int WORDS_PER_PHASE   = 115;
    localparam int N_DIRECTED        = 24;
    localparam int SAT_START         = 10;
    localparam int ABOVE_RANGE_START = 18;
    localparam int UPDATE_DRAIN      = 320;
    localparam int END_DRAIN         = 600;
    localparam int LONG_HOLD         = 3000;
    localparam int HOLD_AT           = 400;
    localparam int QUIET_LIMIT       = 20000;
    localparam int SHIFT_RANDOM      = 64;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [31:0]                 s_axis_tdata  = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [31:0]                 m_axis_tdata;
    logic                        i_cfg_valid   = 1'b0;
    logic                        o_cfg_ready;
    logic [lms_pkg::SHIFT_W-1:0] i_cfg_data    = '0;

    int fail_count;
    int pending;
    int sent_cnt     = 0;
    int quiet_cycles = 0;
    bit idle_en      = 1'b1;

    int shift_plan [N_PHASES] = '{12, 63, 0, 47, 16, SHIFT_RANDOM, 8, SHIFT_RANDOM, 24,
                                  SHIFT_RANDOM};
    int amp_plan [N_PHASES] = '{32767, 2000, 32767, 300, 8000, 32767, 1000, 32767, 16000,
                                4000};

    // Each word is {desired_sample, reference_sample}.
    logic [31:0] directed_words [N_DIRECTED] = '{
        32'h0000_0000, 32'h7FFF_7FFF, 32'h8000_8000, 32'h8000_7FFF, 32'h7FFF_8000,
        32'hFFFF_0001, 32'h0001_FFFF, 32'hAAAA_5555, 32'h5555_AAAA, 32'h0000_7FFF,
        32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h8000_7FFF, 32'h8000_8000,
        32'h8000_8000, 32'h7FFF_8000, 32'h0000_7FFF,
        32'h7FFF_7FFF, 32'h8000_7FFF, 32'h1234_8000, 32'h0000_0000, 32'h8000_8000,
        32'h7FFF_0001
    };

    always #2 i_clk = ~i_clk;

    lms_adaptive_fir_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    lms_fir_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic [15:0] pick_sample(input int unsigned amp);
        int unsigned sel;
        int          v;
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
            return 16'h8000;
        end
        if (sel == 1) begin
            return 16'h7FFF;
        end
        if (sel == 2) begin
            return 16'h0000;
        end
        if (sel == 3) begin
            return 16'($urandom);
        end
        v = int'($urandom_range(0, 2 * amp)) - int'(amp);
        return v[15:0];
    endfunction

    task automatic send_word(input logic [31:0] word);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        sent_cnt <= sent_cnt + 1;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // The update pass still runs after the last output word, so the core is given
    // time to finish it before the step shift changes.
    task automatic write_step_shift(input logic [lms_pkg::SHIFT_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (UPDATE_DRAIN) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [15:0] ref_w;
        logic [15:0] des_w;
        int          ref_i;
        int          des_i;
        int          prev1;
        int          prev2;
        prev1 = 0;
        prev2 = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < N_DIRECTED; k++) begin
            if (k == SAT_START) begin
                write_step_shift(6'd0);
            end
            if (k == ABOVE_RANGE_START) begin
                write_step_shift(6'd63);
            end
            send_word(directed_words[k]);
        end
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (shift_plan[ph] == SHIFT_RANDOM) begin
                write_step_shift(6'($urandom_range(0, 63)));
            end else begin
                write_step_shift(6'(shift_plan[ph]));
            end
            if (ph == N_PHASES - 1) begin
                idle_en <= 1'b0;
            end
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                ref_w = pick_sample(amp_plan[ph]);
                ref_i = int'($signed(ref_w));
                // Mostly a fixed three-tap plant with a little noise, so that the
                // weights adapt toward a real solution; the rest is unrelated data.
                if ($urandom_range(0, 3) != 0) begin
                    des_i = (ref_i >>> 1) + (prev1 >>> 2) - (prev2 >>> 3)
                            + int'($urandom_range(0, 32)) - 16;
                    des_w = des_i[15:0];
                end else begin
                    des_w = pick_sample(32767);
                end
                prev2 = prev1;
                prev1 = ref_i;
                send_word({des_w, ref_w});
            end
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (END_DRAIN) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : sink
        bit hold_done;
        hold_done = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!hold_done && sent_cnt >= HOLD_AT) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

FILE: sim.f
+incdir+design
design/lms_pkg.sv
design/lms_ram.sv
design/lms_ctrl.sv
design/lms_dp.sv
design/lms_adaptive_fir_core.sv
bench/lms_fir_checker.sv
bench/lms_adaptive_fir_core_tb.sv
